@@ hw/rtl/erl_pkg.sv @@
// Package with shared types and constants for the event ring log.
package erl_pkg;

   localparam int LogDepth = 1024;
   localparam int AddrW = $clog2(LogDepth);
   localparam int CountW = AddrW + 1;

   localparam logic [1:0] CmdPush  = 2'd0;
   localparam logic [1:0] CmdRead  = 2'd1;
   localparam logic [1:0] CmdStats = 2'd2;
   localparam logic [1:0] CmdSpare = 2'd3;

   localparam logic [1:0] RegTxOk   = 2'd0;
   localparam logic [1:0] RegTxLost = 2'd1;
   localparam logic [1:0] RegRelay  = 2'd2;
   localparam logic [1:0] RegRxOk   = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         flag_bits;
      logic signed [7:0]  rssi;
      logic signed [7:0]  snr_quarter;
      logic [7:0]         sequence_req;
      logic [31:0]        stamp_ms;
      logic [9:0]         read_index;
   } req_type;

   typedef struct packed {
      logic [10:0]        entry_count;
      logic               entry_valid;
      logic [63:0]        entry_word;
      logic [10:0]        tx_ok_total;
      logic [10:0]        tx_lost_total;
      logic [10:0]        relay_total;
      logic [10:0]        rx_ok_total;
      logic signed [7:0]  rssi_average;
      logic signed [7:0]  rssi_lowest;
      logic signed [7:0]  rssi_highest;
      logic [31:0]        mean_rx_interval_ms;
   } rsp_type;

endpackage

@@ hw/rtl/erl_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit unsigned operands.
module erl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/event_ring_log_with_link_stats.sv @@
// Top level of the event ring log with link statistics.
// The log keeps up to 1024 64-bit entries in one synchronous memory with a
// registered read port; once full, each push overwrites the oldest entry.
// One request is handled at a time. A push writes the memory and goes straight
// to the response state; a read in range first waits for the registered memory
// read, and a read out of range goes straight to the response state. A
// statistics request walks every valid entry from oldest to newest, one memory
// read per cycle, then makes two passes of a shared restoring divider (the RSSI
// average, then the mean rx-ok interval). The result is held in an output
// register until its transfer completes; the next request is taken only after
// that. Configuration writes update the four flag masks and are expected only
// while the block is idle; writes to an index above three are ignored.
module event_ring_log_with_link_stats (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  erl_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output erl_pkg::rsp_type   rsp_data,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   typedef enum logic [2:0] {
      IDLE, RDWAIT, WALK, DIVAVG, DIVGAP, RESPOND
   } state_type;

   // The memory holding the log itself.
   logic [63:0] mem [erl_pkg::LogDepth];
   logic [63:0] mem_q;
   logic        mem_we;
   logic [erl_pkg::AddrW-1:0] mem_waddr, mem_raddr;
   logic [63:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[mem_raddr];
   end

   state_type state_ff, state_in;
   logic [7:0] txm_ff, txm_in, lostm_ff, lostm_in, relm_ff, relm_in, rxm_ff, rxm_in;
   logic [erl_pkg::AddrW-1:0]  wp_ff, wp_in;
   logic [erl_pkg::CountW-1:0] cnt_ff, cnt_in;
   erl_pkg::rsp_type rsp_ff, rsp_in;

   // Walk state.
   logic [erl_pkg::CountW-1:0] issued_ff, issued_in;   // reads issued
   logic [erl_pkg::CountW-1:0] seen_ff, seen_in;       // entries consumed
   logic        qv_ff, qv_in;                          // mem_q carries an entry
   logic [10:0] ntx_ff, ntx_in, nlost_ff, nlost_in, nrel_ff, nrel_in, nrx_ff, nrx_in;
   logic [10:0] nsmp_ff, nsmp_in, ngap_ff, ngap_in;
   logic signed [18:0] sum_ff, sum_in;
   logic signed [7:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] last_ff, last_in, gsum_ff, gsum_in;
   logic        haverx_ff, haverx_in;
   logic        neg_ff, neg_in;

   logic        div_start, div_done;
   logic [31:0] div_a, div_b, div_q;

   erl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   logic [erl_pkg::AddrW-1:0] base;
   logic [7:0]        fl;
   logic signed [7:0] r;
   logic [31:0]       t;
   logic [18:0]       abs_sum;
   logic [31:0]       neg_q;

   always_comb begin
      base = (cnt_ff == erl_pkg::CountW'(erl_pkg::LogDepth)) ? wp_ff : '0;
      fl = mem_q[7:0];
      r  = mem_q[31:24];
      t  = mem_q[63:32];
      abs_sum = sum_ff[18] ? 19'(-sum_ff) : 19'(sum_ff);
      neg_q = -div_q;

      state_in = state_ff;
      txm_in = txm_ff; lostm_in = lostm_ff; relm_in = relm_ff; rxm_in = rxm_ff;
      wp_in = wp_ff; cnt_in = cnt_ff; rsp_in = rsp_ff;
      issued_in = issued_ff; seen_in = seen_ff; qv_in = 1'b0;
      ntx_in = ntx_ff; nlost_in = nlost_ff; nrel_in = nrel_ff; nrx_in = nrx_ff;
      nsmp_in = nsmp_ff; ngap_in = ngap_ff; sum_in = sum_ff; lo_in = lo_ff; hi_in = hi_ff;
      last_in = last_ff; gsum_in = gsum_ff; haverx_in = haverx_ff; neg_in = neg_ff;
      mem_we = 1'b0; mem_waddr = wp_ff; mem_raddr = base + req_data.read_index;
      mem_wdata = {req_data.stamp_ms, req_data.rssi, req_data.snr_quarter,
                   req_data.sequence_req, req_data.flag_bits};
      div_start = 1'b0; div_a = '0; div_b = '0;
      req_stall = (state_ff != IDLE);

      if (csr_write) begin
         unique case (csr_index)
            erl_pkg::RegTxOk:   txm_in = csr_wdata;
            erl_pkg::RegTxLost: lostm_in = csr_wdata;
            erl_pkg::RegRelay:  relm_in = csr_wdata;
            erl_pkg::RegRxOk:   rxm_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               rsp_in = '0;
               rsp_in.entry_count = cnt_ff;
               unique case (req_data.cmd)
                  erl_pkg::CmdPush: begin
                     mem_we = 1'b1;
                     wp_in = wp_ff + 1'b1;
                     if (cnt_ff != erl_pkg::CountW'(erl_pkg::LogDepth)) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                     rsp_in.entry_count = cnt_in;
                     state_in = RESPOND;
                  end
                  erl_pkg::CmdRead: begin
                     if ({1'b0, req_data.read_index} < cnt_ff) begin
                        rsp_in.entry_valid = 1'b1;
                        state_in = RDWAIT;
                     end else begin
                        state_in = RESPOND;
                     end
                  end
                  erl_pkg::CmdStats: begin
                     issued_in = '0; seen_in = '0;
                     ntx_in = '0; nlost_in = '0; nrel_in = '0; nrx_in = '0;
                     nsmp_in = '0; ngap_in = '0; sum_in = '0;
                     lo_in = 8'sd127; hi_in = -8'sd128;
                     last_in = '0; gsum_in = '0; haverx_in = 1'b0;
                     state_in = WALK;
                  end
                  default: state_in = RESPOND;
               endcase
            end
         end
         RDWAIT: begin
            rsp_in.entry_word = mem_q;
            state_in = RESPOND;
         end
         WALK: begin
            mem_raddr = base + issued_ff[erl_pkg::AddrW-1:0];
            if (issued_ff < cnt_ff) begin
               issued_in = issued_ff + 1'b1;
               qv_in = 1'b1;
            end
            if (qv_ff) begin
               seen_in = seen_ff + 1'b1;
               if ((fl & txm_ff) != 0) ntx_in = ntx_ff + 1'b1;
               if ((fl & lostm_ff) != 0) nlost_in = nlost_ff + 1'b1;
               if ((fl & relm_ff) != 0) nrel_in = nrel_ff + 1'b1;
               if ((fl & rxm_ff) != 0) begin
                  nrx_in = nrx_ff + 1'b1;
                  if (haverx_ff) begin
                     gsum_in = gsum_ff + (t - last_ff);
                     ngap_in = ngap_ff + 1'b1;
                  end
                  last_in = t;
                  haverx_in = 1'b1;
               end
               if ((fl & (txm_ff | rxm_ff)) != 0) begin
                  sum_in = sum_ff + 19'(r);
                  if (r < lo_ff) lo_in = r;
                  if (r > hi_ff) hi_in = r;
                  nsmp_in = nsmp_ff + 1'b1;
               end
            end
            if (!qv_ff && issued_ff == cnt_ff) begin
               rsp_in.tx_ok_total = ntx_ff;
               rsp_in.tx_lost_total = nlost_ff;
               rsp_in.relay_total = nrel_ff;
               rsp_in.rx_ok_total = nrx_ff;
               if (nsmp_ff != 0) begin
                  rsp_in.rssi_lowest = lo_ff;
                  rsp_in.rssi_highest = hi_ff;
               end
               div_start = 1'b1;
               div_a = 32'(abs_sum);
               div_b = (nsmp_ff != 0) ? 32'(nsmp_ff) : 32'd1;
               neg_in = sum_ff[18];
               state_in = DIVAVG;
            end
         end
         DIVAVG: begin
            if (div_done) begin
               if (nsmp_ff != 0) begin
                  rsp_in.rssi_average = neg_ff ? neg_q[7:0] : div_q[7:0];
               end
               div_start = 1'b1;
               div_a = gsum_ff;
               div_b = (ngap_ff != 0) ? 32'(ngap_ff) : 32'd1;
               state_in = DIVGAP;
            end
         end
         DIVGAP: begin
            if (div_done) begin
               if (ngap_ff != 0) rsp_in.mean_rx_interval_ms = div_q;
               state_in = RESPOND;
            end
         end
         RESPOND: begin
            if (!rsp_stall) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      issued_ff <= issued_in; seen_ff <= seen_in;
      ntx_ff <= ntx_in; nlost_ff <= nlost_in; nrel_ff <= nrel_in; nrx_ff <= nrx_in;
      nsmp_ff <= nsmp_in; ngap_ff <= ngap_in; sum_ff <= sum_in;
      lo_ff <= lo_in; hi_ff <= hi_in; last_ff <= last_in; gsum_ff <= gsum_in;
      haverx_ff <= haverx_in; neg_ff <= neg_in;
      if (reset) begin
         state_ff <= IDLE;
         txm_ff <= 8'd1; lostm_ff <= 8'd2; relm_ff <= 8'd4; rxm_ff <= 8'd8;
         wp_ff <= '0; cnt_ff <= '0; qv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         txm_ff <= txm_in; lostm_ff <= lostm_in; relm_ff <= relm_in; rxm_ff <= rxm_in;
         wp_ff <= wp_in; cnt_ff <= cnt_in; qv_ff <= qv_in;
      end
   end

   assign rsp_valid = (state_ff == RESPOND);
   assign rsp_data  = rsp_ff;

endmodule
